// ===== hdl/veul_pkg.sv =====
// Shared types, constants and the arc-tangent table for the Euler rotation unit.
package veul_pkg;

   // Field widths and CORDIC length.
   localparam int COMP_WIDTH    = 16;
   localparam int ANGLE_WIDTH   = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int STAGE_W       = $clog2(CORDIC_STAGES);

   // Sine and cosine are Q28; the angle accumulator works in 2^-32 turns.
   localparam int TRIG_FRAC = 28;
   localparam int TRIG_W    = 31;
   localparam int ZW        = 34;
   localparam int ACC_W     = COMP_WIDTH + 4;
   localparam int PROD_W    = ACC_W + TRIG_W;
   localparam int SUM_W     = PROD_W + 1;

   localparam logic signed [TRIG_W-1:0] GAIN_Q28 = TRIG_W'(163008219);
   localparam logic signed [SUM_W-1:0]  HALF_LSB = SUM_W'(1) <<< (TRIG_FRAC - 1);

   // Which pair of components one rotation step turns.
   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef struct packed {
      logic signed [COMP_WIDTH-1:0] vec_x;
      logic signed [COMP_WIDTH-1:0] vec_y;
      logic signed [COMP_WIDTH-1:0] vec_z;
      logic [ANGLE_WIDTH-1:0]       angle_x;
      logic [ANGLE_WIDTH-1:0]       angle_y;
      logic [ANGLE_WIDTH-1:0]       angle_z;
   } req_type;

   typedef struct packed {
      logic signed [COMP_WIDTH-1:0] rot_x;
      logic signed [COMP_WIDTH-1:0] rot_y;
      logic signed [COMP_WIDTH-1:0] rot_z;
      logic                         saturated;
   } rsp_type;

   // One CORDIC accumulator set plus the quadrant it will be folded into.
   typedef struct packed {
      logic signed [TRIG_W-1:0] x;
      logic signed [TRIG_W-1:0] y;
      logic signed [ZW-1:0]     z;
      logic [1:0]               q;
   } trig_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] x;
      logic signed [ACC_W-1:0] y;
      logic signed [ACC_W-1:0] z;
   } vec3_type;

   typedef struct packed {
      vec3_type v;
      trig_type tx;
      trig_type ty;
      trig_type tz;
   } cordic_data_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] c;
      logic signed [TRIG_W-1:0] s;
   } cs_type;

   typedef struct packed {
      vec3_type v;
      cs_type   csx;
      cs_type   csy;
      cs_type   csz;
   } rot_data_type;

   // Arc-tangent of 2^-i in units of 2^-32 turns.
   function automatic logic signed [ZW-1:0] atan_turn(input logic [4:0] idx);
      logic [31:0] t;
      unique case (idx)
         5'd0:  t = 32'h20000000;
         5'd1:  t = 32'h12E4051E;
         5'd2:  t = 32'h09FB385B;
         5'd3:  t = 32'h051111D4;
         5'd4:  t = 32'h028B0D43;
         5'd5:  t = 32'h0145D7E1;
         5'd6:  t = 32'h00A2F61E;
         5'd7:  t = 32'h00517C55;
         5'd8:  t = 32'h0028BE53;
         5'd9:  t = 32'h00145F2F;
         5'd10: t = 32'h000A2F98;
         5'd11: t = 32'h000517CC;
         5'd12: t = 32'h00028BE6;
         5'd13: t = 32'h000145F3;
         5'd14: t = 32'h0000A2FA;
         5'd15: t = 32'h0000517D;
         5'd16: t = 32'h000028BE;
         5'd17: t = 32'h0000145F;
         5'd18: t = 32'h00000A30;
         5'd19: t = 32'h00000518;
         5'd20: t = 32'h0000028C;
         5'd21: t = 32'h00000146;
         5'd22: t = 32'h000000A3;
         5'd23: t = 32'h00000051;
         default: t = 32'h0;
      endcase
      return $signed({{(ZW-32){1'b0}}, t});
   endfunction

   // One micro-rotation; the shifts are arithmetic, so they round towards minus infinity.
   function automatic trig_type cordic_step(input trig_type t, input logic [STAGE_W-1:0] idx);
      trig_type             r;
      logic signed [TRIG_W-1:0] dx;
      logic signed [TRIG_W-1:0] dy;
      logic signed [ZW-1:0]     at;
      dx = t.x >>> idx;
      dy = t.y >>> idx;
      at = atan_turn(5'(idx));
      r  = t;
      if (!t.z[ZW-1]) begin
         r.x = t.x - dy;
         r.y = t.y + dx;
         r.z = t.z - at;
      end else begin
         r.x = t.x + dy;
         r.y = t.y - dx;
         r.z = t.z + at;
      end
      return r;
   endfunction

   // Fold the first-quadrant result into the quadrant given by the top angle bits.
   function automatic cs_type fold_quadrant(input trig_type t);
      cs_type r;
      unique case (t.q)
         2'd0: begin r.c = t.x;  r.s = t.y;  end
         2'd1: begin r.c = -t.y; r.s = t.x;  end
         2'd2: begin r.c = -t.x; r.s = -t.y; end
         2'd3: begin r.c = t.y;  r.s = -t.x; end
         default: begin r.c = t.x; r.s = t.y; end
      endcase
      return r;
   endfunction

   // Seed a CORDIC accumulator from an angle.
   function automatic trig_type cordic_seed(input logic [ANGLE_WIDTH-1:0] ang);
      trig_type r;
      r.x = GAIN_Q28;
      r.y = '0;
      r.z = $signed(ZW'(ang[ANGLE_WIDTH-3:0]) << (32 - ANGLE_WIDTH));
      r.q = ang[ANGLE_WIDTH-1:ANGLE_WIDTH-2];
      return r;
   endfunction

endpackage

// ===== hdl/vector_euler_rotation_xyz_unit.sv =====
// Top level of the Euler-angle vector rotator: CORDIC row, three rotation cells, output stage.
// Rotates a Q3.12 vector about x, then y, then z by angles given as fractions of a turn,
// and returns the saturated result with a flag that reports clipping. A new vector is
// taken every clock cycle while no stall holds the cells; each one passes through the
// cells of the CORDIC row, which works out sine and cosine of all three angles at once,
// then through the three rotation cells (multiply, then round and sum), and last through
// the saturating output register. Each cell holds a beat until the next one takes it,
// so a stall at the output only stops the cells that are full.
module vector_euler_rotation_xyz_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  veul_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output veul_pkg::rsp_type rsp_data
);
   import veul_pkg::*;

   localparam logic signed [ACC_W-1:0] COMP_MAX = ACC_W'((1 << (COMP_WIDTH - 1)) - 1);
   localparam logic signed [ACC_W-1:0] COMP_MIN = -COMP_MAX - ACC_W'(1);

   logic            cv [CORDIC_STAGES+1];
   logic            cr [CORDIC_STAGES+1];
   cordic_data_type cd [CORDIC_STAGES+1];
   logic            rv [4];
   logic            rr [4];
   rot_data_type    rd [4];
   logic            rsp_valid_ff;
   rsp_type         rsp_ff;
   rsp_type         rsp_in;
   logic            out_ready;

   // Seed the CORDIC row from the request beat.
   always_comb begin
      cd[0].v.x = ACC_W'(req_data.vec_x);
      cd[0].v.y = ACC_W'(req_data.vec_y);
      cd[0].v.z = ACC_W'(req_data.vec_z);
      cd[0].tx  = cordic_seed(req_data.angle_x);
      cd[0].ty  = cordic_seed(req_data.angle_y);
      cd[0].tz  = cordic_seed(req_data.angle_z);
   end
   assign cv[0]     = req_valid;
   assign req_ready = cr[0];

   // Row of CORDIC cells.
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      veul_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (STAGE_W'(i)),
         .in_valid  (cv[i]),
         .in_ready  (cr[i]),
         .in_data   (cd[i]),
         .out_valid (cv[i+1]),
         .out_ready (cr[i+1]),
         .out_data  (cd[i+1])
      );
   end

   // Fold quadrants into signed sine and cosine for the rotation cells.
   always_comb begin
      rd[0].v   = cd[CORDIC_STAGES].v;
      rd[0].csx = fold_quadrant(cd[CORDIC_STAGES].tx);
      rd[0].csy = fold_quadrant(cd[CORDIC_STAGES].ty);
      rd[0].csz = fold_quadrant(cd[CORDIC_STAGES].tz);
   end
   assign rv[0]             = cv[CORDIC_STAGES];
   assign cr[CORDIC_STAGES] = rr[0];

   veul_rot_cell u_rot_x (
      .clock(clock), .reset(reset), .axis(AXIS_X),
      .in_valid(rv[0]), .in_ready(rr[0]), .in_data(rd[0]),
      .out_valid(rv[1]), .out_ready(rr[1]), .out_data(rd[1])
   );
   veul_rot_cell u_rot_y (
      .clock(clock), .reset(reset), .axis(AXIS_Y),
      .in_valid(rv[1]), .in_ready(rr[1]), .in_data(rd[1]),
      .out_valid(rv[2]), .out_ready(rr[2]), .out_data(rd[2])
   );
   veul_rot_cell u_rot_z (
      .clock(clock), .reset(reset), .axis(AXIS_Z),
      .in_valid(rv[2]), .in_ready(rr[2]), .in_data(rd[2]),
      .out_valid(rv[3]), .out_ready(rr[3]), .out_data(rd[3])
   );

   // Clip each component to the output range and note any clipping.
   always_comb begin
      rsp_in.saturated = 1'b0;
      if (rd[3].v.x > COMP_MAX) begin
         rsp_in.rot_x = COMP_MAX[COMP_WIDTH-1:0];  rsp_in.saturated = 1'b1;
      end else if (rd[3].v.x < COMP_MIN) begin
         rsp_in.rot_x = COMP_MIN[COMP_WIDTH-1:0];  rsp_in.saturated = 1'b1;
      end else begin
         rsp_in.rot_x = rd[3].v.x[COMP_WIDTH-1:0];
      end
      if (rd[3].v.y > COMP_MAX) begin
         rsp_in.rot_y = COMP_MAX[COMP_WIDTH-1:0];  rsp_in.saturated = 1'b1;
      end else if (rd[3].v.y < COMP_MIN) begin
         rsp_in.rot_y = COMP_MIN[COMP_WIDTH-1:0];  rsp_in.saturated = 1'b1;
      end else begin
         rsp_in.rot_y = rd[3].v.y[COMP_WIDTH-1:0];
      end
      if (rd[3].v.z > COMP_MAX) begin
         rsp_in.rot_z = COMP_MAX[COMP_WIDTH-1:0];  rsp_in.saturated = 1'b1;
      end else if (rd[3].v.z < COMP_MIN) begin
         rsp_in.rot_z = COMP_MIN[COMP_WIDTH-1:0];  rsp_in.saturated = 1'b1;
      end else begin
         rsp_in.rot_z = rd[3].v.z[COMP_WIDTH-1:0];
      end
   end

   // Output register.
   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign rr[3]     = out_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= rv[3];
      end
      if (out_ready && rv[3]) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef NO_ASSERTIONS
   // With the output register empty, every cell upstream can take a beat.
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("request side stalled while the output register is empty");

   // A clipped result must carry a component at one end of the range.
   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.saturated) |->
         (rsp_ff.rot_x == COMP_MAX[COMP_WIDTH-1:0] || rsp_ff.rot_x == COMP_MIN[COMP_WIDTH-1:0] ||
          rsp_ff.rot_y == COMP_MAX[COMP_WIDTH-1:0] || rsp_ff.rot_y == COMP_MIN[COMP_WIDTH-1:0] ||
          rsp_ff.rot_z == COMP_MAX[COMP_WIDTH-1:0] || rsp_ff.rot_z == COMP_MIN[COMP_WIDTH-1:0]))
      else $error("saturation flag without a clipped component");

   // Nothing is offered in the cycle after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("result offered straight after reset");
`endif

endmodule

// ===== hdl/veul_cordic_cell.sv =====
// One CORDIC iteration for all three angles, with the vector carried alongside.
module veul_cordic_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [veul_pkg::STAGE_W-1:0] stage_idx,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  veul_pkg::cordic_data_type   in_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output veul_pkg::cordic_data_type   out_data
);
   import veul_pkg::*;

   logic            valid_ff;
   cordic_data_type data_ff;
   cordic_data_type data_in;

   // The cell may take a beat when empty or when its own beat is leaving.
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Advance each of the three angle accumulators by one step.
   always_comb begin
      data_in    = in_data;
      data_in.tx = cordic_step(in_data.tx, stage_idx);
      data_in.ty = cordic_step(in_data.ty, stage_idx);
      data_in.tz = cordic_step(in_data.tz, stage_idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== hdl/veul_rot_cell.sv =====
// One plane rotation: a multiply stage followed by a round-and-sum stage.
module veul_rot_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  veul_pkg::axis_type     axis,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  veul_pkg::rot_data_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output veul_pkg::rot_data_type out_data
);
   import veul_pkg::*;

   logic                     mul_valid_ff;
   rot_data_type             mul_data_ff;
   logic signed [PROD_W-1:0] pac_ff, pbs_ff, pbc_ff, pas_ff;
   logic                     sum_valid_ff;
   rot_data_type             sum_data_ff;
   rot_data_type             sum_data_in;
   logic                     mul_ready;
   logic                     sum_ready;
   logic signed [PROD_W-1:0] a_ext, b_ext, c_ext, s_ext;
   cs_type                   cs_sel;
   logic signed [SUM_W-1:0]  na_sum, nb_sum;
   logic signed [SUM_W-1:0]  na_shift, nb_shift;

   assign sum_ready = !sum_valid_ff || out_ready;
   assign mul_ready = !mul_valid_ff || sum_ready;
   assign in_ready  = mul_ready;
   assign out_valid = sum_valid_ff;
   assign out_data  = sum_data_ff;

   // Pick the component pair and the angle for this axis.
   always_comb begin
      unique case (axis)
         AXIS_X: begin
            a_ext  = PROD_W'(in_data.v.y);
            b_ext  = PROD_W'(in_data.v.z);
            cs_sel = in_data.csx;
         end
         AXIS_Y: begin
            a_ext  = PROD_W'(in_data.v.x);
            b_ext  = PROD_W'(in_data.v.z);
            cs_sel = in_data.csy;
         end
         default: begin
            a_ext  = PROD_W'(in_data.v.x);
            b_ext  = PROD_W'(in_data.v.y);
            cs_sel = in_data.csz;
         end
      endcase
      c_ext = PROD_W'(cs_sel.c);
      s_ext = PROD_W'(cs_sel.s);
   end

   // Round the Q28 sums back to integer components and write them into place.
   always_comb begin
      na_sum      = SUM_W'(pac_ff) + SUM_W'(pbs_ff) + HALF_LSB;
      nb_sum      = SUM_W'(pbc_ff) - SUM_W'(pas_ff) + HALF_LSB;
      na_shift    = na_sum >>> TRIG_FRAC;
      nb_shift    = nb_sum >>> TRIG_FRAC;
      sum_data_in = mul_data_ff;
      unique case (axis)
         AXIS_X: begin
            sum_data_in.v.y = na_shift[ACC_W-1:0];
            sum_data_in.v.z = nb_shift[ACC_W-1:0];
         end
         AXIS_Y: begin
            sum_data_in.v.x = na_shift[ACC_W-1:0];
            sum_data_in.v.z = nb_shift[ACC_W-1:0];
         end
         default: begin
            sum_data_in.v.x = na_shift[ACC_W-1:0];
            sum_data_in.v.y = nb_shift[ACC_W-1:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         if (mul_ready) begin
            mul_valid_ff <= in_valid;
         end
         if (sum_ready) begin
            sum_valid_ff <= mul_valid_ff;
         end
      end
      if (mul_ready && in_valid) begin
         mul_data_ff <= in_data;
         pac_ff      <= a_ext * c_ext;
         pbs_ff      <= b_ext * s_ext;
         pbc_ff      <= b_ext * c_ext;
         pas_ff      <= a_ext * s_ext;
      end
      if (sum_ready && mul_valid_ff) begin
         sum_data_ff <= sum_data_in;
      end
   end

endmodule

// ===== sim/tb_checker.sv =====
// Checker for the Euler rotation unit: predicts each result beat and compares it with the output.
`timescale 1ns / 1ps

module tb_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  veul_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  veul_pkg::rsp_type rsp_data,
   output int                error_count,
   output int                pending_count,
   output int                rsp_count,
   output int                sat_count
);
   import veul_pkg::*;

   localparam longint TURN_HALF = longint'(1) << (TRIG_FRAC - 1);

   rsp_type rotated_q[$];

   // Arc-tangent of 2^-i in 2^-32 turn units.
   function automatic longint atan_entry(input int i);
      longint tab [0:23] = '{
         64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
         64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
         64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
         64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
         64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
         64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
      return tab[i];
   endfunction

   // Cosine and sine of an angle in Q28, quadrant folded.
   function automatic void angle_trig(input logic [ANGLE_WIDTH-1:0] ang,
                                      output longint c, output longint s);
      longint cx, sy, zr, dx, dy;
      logic [1:0] quad;
      quad = ang[ANGLE_WIDTH-1 -: 2];
      zr   = longint'(ang[ANGLE_WIDTH-3:0]) << (32 - ANGLE_WIDTH);
      cx   = 163008219;
      sy   = 0;
      for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
         dx = sy >>> i;
         dy = cx >>> i;
         if (zr >= 0) begin
            cx -= dx; sy += dy; zr -= atan_entry(i);
         end else begin
            cx += dx; sy -= dy; zr += atan_entry(i);
         end
      end
      case (quad)
         2'd0: begin c = cx;  s = sy;  end
         2'd1: begin c = -sy; s = cx;  end
         2'd2: begin c = -cx; s = -sy; end
         default: begin c = sy; s = -cx; end
      endcase
   endfunction

   // One plane rotation with round-half-up to the component grid.
   function automatic void turn_plane(inout longint a, inout longint b,
                                      input logic [ANGLE_WIDTH-1:0] ang);
      longint c, s, na, nb;
      angle_trig(ang, c, s);
      na = (a * c + b * s + TURN_HALF) >>> TRIG_FRAC;
      nb = (b * c - a * s + TURN_HALF) >>> TRIG_FRAC;
      a  = na;
      b  = nb;
   endfunction

   function automatic logic signed [COMP_WIDTH-1:0] clip_comp(input longint v,
                                                              inout logic flag);
      longint hi, lo;
      hi = (longint'(1) << (COMP_WIDTH - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin v = hi; flag = 1'b1; end
      if (v < lo) begin v = lo; flag = 1'b1; end
      return v[COMP_WIDTH-1:0];
   endfunction

   function automatic rsp_type rotate_xyz(input req_type r);
      rsp_type o;
      longint  x, y, z;
      logic    sat;
      x = longint'(r.vec_x);
      y = longint'(r.vec_y);
      z = longint'(r.vec_z);
      sat = 1'b0;
      turn_plane(y, z, r.angle_x);
      turn_plane(x, z, r.angle_y);
      turn_plane(x, y, r.angle_z);
      o.rot_x = clip_comp(x, sat);
      o.rot_y = clip_comp(y, sat);
      o.rot_z = clip_comp(z, sat);
      o.saturated = sat;
      return o;
   endfunction

   assign pending_count = rotated_q.size();

   // Predict on each accepted request beat, compare on each accepted result beat.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rotated_q.delete();
         error_count <= 0;
         rsp_count   <= 0;
         sat_count   <= 0;
      end else begin
         if (req_valid && req_ready)
            rotated_q.push_back(rotate_xyz(req_data));
         if (rsp_valid && rsp_ready) begin
            rsp_count <= rsp_count + 1;
            if (rsp_data.saturated)
               sat_count <= sat_count + 1;
            if (rotated_q.size() == 0) begin
               error_count <= error_count + 1;
               if (error_count < 10)
                  $display("checker: result beat with none pending: %h", rsp_data);
            end else begin
               want = rotated_q.pop_front();
               if (want !== rsp_data) begin
                  error_count <= error_count + 1;
                  if (error_count < 10)
                     $display("checker: mismatch x %0d/%0d y %0d/%0d z %0d/%0d sat %0b/%0b",
                              want.rot_x, rsp_data.rot_x, want.rot_y, rsp_data.rot_y,
                              want.rot_z, rsp_data.rot_z, want.saturated,
                              rsp_data.saturated);
               end
            end
         end
      end
   end
endmodule

// ===== sim/tb_top.sv =====
// Top of the Euler rotation testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
   import veul_pkg::*;

   localparam int RANDOM_ITEMS = 2000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      error_count;
   int      pending_count;
   int      rsp_count;
   int      sat_count;
   int      sent_count;
   logic    hold_off_done;

   vector_euler_rotation_xyz_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   tb_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .error_count(error_count), .pending_count(pending_count),
      .rsp_count(rsp_count), .sat_count(sat_count)
   );

   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   // Mostly short gaps, now and then a long one, sometimes none.
   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [15:0] random_comp();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($signed($urandom_range(0, 8191)) - 4096);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] random_angle();
      case ($urandom_range(0, 4))
         0: return 16'($urandom_range(0, 3)) << 14;
         1: return (16'($urandom_range(0, 3)) << 14) + 16'($urandom_range(0, 15)) - 16'd8;
         default: return 16'($urandom);
      endcase
   endfunction

   // Offer one beat, hold it until accepted, then idle for a gap.
   task automatic send_beat(input req_type item);
      int gap;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sent_count++;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Receiver: one long hold-off early on, then random stalls.
   initial begin
      int stall;
      rsp_ready     <= 1'b0;
      hold_off_done <= 1'b0;
      @(posedge clock iff !reset);
      repeat (200) @(posedge clock);
      hold_off_done <= 1'b1;
      forever begin
         rsp_ready <= 1'b1;
         @(posedge clock);
         if ($urandom_range(0, 3) == 0) begin
            stall = gap_length();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
      end
   end

   // Stimulus: directed corner beats, then random ones.
   initial begin
      req_type item;
      logic [15:0] comps [0:4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h1000};
      logic [15:0] angs [0:5]  = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h2000};
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_data   <= '0;
      sent_count = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < 24; i++) begin
         item.vec_x   = comps[i % 5];
         item.vec_y   = comps[(i + 1) % 5];
         item.vec_z   = comps[(i + 3) % 5];
         item.angle_x = angs[i % 6];
         item.angle_y = angs[(i / 2) % 6];
         item.angle_z = angs[(i / 4) % 6];
         send_beat(item);
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         item.vec_x   = random_comp();
         item.vec_y   = random_comp();
         item.vec_z   = random_comp();
         item.angle_x = random_angle();
         item.angle_y = random_angle();
         item.angle_z = random_angle();
         send_beat(item);
      end
      req_valid <= 1'b0;
      while (pending_count != 0 || !hold_off_done) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Sent %0d vectors and checked %0d rotated results, %0d of them clipped.",
               sent_count, rsp_count, sat_count);
      $display("Directed corners covered extreme components and quadrant boundary angles.");
      if (error_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

   // Watchdog.
   initial begin
      #2000000;
      $display("tb_top: errors");
      $finish;
   end
endmodule
